// ----- sv/kppa_pkg.sv -----
package kppa_pkg;

    // field widths of the item and result payloads
    localparam int CMD_W     = 1;
    localparam int SIZE_W    = 16;
    localparam int LAYOUT_W  = 8;
    localparam int POOLNUM_W = 4;
    localparam int PAGENUM_W = 8;
    localparam int STATUS_W  = 3;
    localparam int OFFSET_W  = 24;
    localparam int CAP_W     = 24;

    // packed stream widths; the tdata widths are rounded up to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;

    // pool capacity reset value and offset saturation limit
    localparam logic [CAP_W-1:0]    CAP_RESET  = 24'd65536;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 24'hFFFFFF;

endpackage

// ----- sv/keyed_page_pool_allocator.sv -----
// channel    | direction | signals                               | payload
// -----------+-----------+---------------------------------------+-----------------------------
// cfg        | in        | cfg_valid, cfg_ready, cfg_data        | pool_capacity (24 bit)
// s_axis     | in        | s_axis_tvalid/tready/tdata/tuser      | one allocate or free request
// m_axis     | out       | m_axis_tvalid/tready/tdata/tuser      | one result per request
//
// one request at a time; s_axis_tready is high only while the sequencer is idle
// free: FREE_RD, FREE_CHK; alloc hit: SCAN_RD, SCAN_CMP per slot scanned, then POP, POP_RD, MUL
// a new pool adds CREATE and MAKE around the bit-serial restoring divider (capacity / page size)
// the free stacks fill lazily through a per-pool low-water mark, so no clearing pass
// rst_n clears the control state and the pool count; slot and stack memories need no reset
// a result waiting on m_axis_tready does not block the next request
module keyed_page_pool_allocator #(
    parameter int MAX_POOLS = 16,
    parameter int MAX_PAGES = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // pool_capacity
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kppa_pkg::CAP_W-1:0]     cfg_data,
    // [15:0] entries_per_page, [23:16] layout_code, [27:24] pool_number,
    // [35:28] page_number, [39:36] zero
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kppa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic [kppa_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // [3:0] pool_given, [11:4] page_given, [35:12] base_offset, [39:36] zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [kppa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [kppa_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import kppa_pkg::*;

    localparam int POOL_W    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int CNT_W     = $clog2(MAX_POOLS + 1);
    localparam int PIDX_W    = $clog2(MAX_PAGES);
    localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
    localparam int CMP_W     = (CNT_W > POOLNUM_W) ? CNT_W : POOLNUM_W;
    localparam int PG_CMP_W  = (PCNT_W > PAGENUM_W) ? PCNT_W : PAGENUM_W;
    localparam int STACK_AW  = POOL_W + PIDX_W;
    localparam int PROD_W    = SIZE_W + PIDX_W;
    localparam int SAT_W     = (PROD_W > OFFSET_W) ? PROD_W : OFFSET_W;
    localparam int DIV_CNT_W = $clog2(CAP_W);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_CREATE   = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_MAKE     = 4'd5;
    localparam logic [3:0] S_POP      = 4'd6;
    localparam logic [3:0] S_POP_RD   = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_FREE_RD  = 4'd9;
    localparam logic [3:0] S_FREE_CHK = 4'd10;
    localparam logic [3:0] S_RESULT   = 4'd11;

    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [LAYOUT_W-1:0] layout;
        logic [PCNT_W-1:0]   total;
        logic [PCNT_W-1:0]   fc;
        logic [PCNT_W-1:0]   mark;
    } slot_rec_t;

    // per-slot key and counters, and the free page stacks
    slot_rec_t         slot_mem  [MAX_POOLS];
    logic [PIDX_W-1:0] stack_mem [1 << STACK_AW];

    // control and working registers
    logic [3:0]           state_reg,      state_next;
    logic [CNT_W-1:0]     created_reg,    created_next;
    logic [CAP_W-1:0]     cap_reg,        cap_next;
    logic [SIZE_W-1:0]    req_size_reg,   req_size_next;
    logic [LAYOUT_W-1:0]  req_layout_reg, req_layout_next;
    logic [PAGENUM_W-1:0] req_page_reg,   req_page_next;
    logic [POOL_W-1:0]    cur_slot_reg,   cur_slot_next;
    logic [PCNT_W-1:0]    cur_total_reg,  cur_total_next;
    logic [PCNT_W-1:0]    cur_fc_reg,     cur_fc_next;
    logic [PCNT_W-1:0]    cur_mark_reg,   cur_mark_next;
    logic [PIDX_W-1:0]    pop_idx_reg,    pop_idx_next;
    logic                 pop_fresh_reg,  pop_fresh_next;
    logic [PIDX_W-1:0]    pg_reg,         pg_next;
    logic [SIZE_W:0]      div_rem_reg,    div_rem_next;
    logic [CAP_W-1:0]     div_quo_reg,    div_quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,    div_cnt_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [POOLNUM_W-1:0] res_pool_reg,   res_pool_next;
    logic [PAGENUM_W-1:0] res_page_reg,   res_page_next;
    logic [OFFSET_W-1:0]  res_off_reg,    res_off_next;
    logic                 m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg,   m_status_next;
    logic [POOLNUM_W-1:0] m_pool_reg,     m_pool_next;
    logic [PAGENUM_W-1:0] m_page_reg,     m_page_next;
    logic [OFFSET_W-1:0]  m_off_reg,      m_off_next;

    // memory ports
    logic                slot_we, slot_re;
    logic [POOL_W-1:0]   slot_waddr, slot_raddr;
    slot_rec_t           slot_wdata, slot_q;
    logic                stk_we, stk_re;
    logic [STACK_AW-1:0] stk_waddr, stk_raddr;
    logic [PIDX_W-1:0]   stk_wdata, stk_q;

    // request fields
    logic [CMD_W-1:0]     in_cmd;
    logic [SIZE_W-1:0]    in_size;
    logic [LAYOUT_W-1:0]  in_layout;
    logic [POOLNUM_W-1:0] in_pnum;
    logic [PAGENUM_W-1:0] in_page;

    // shared datapath terms
    logic [SIZE_W:0]     rem_sh;
    logic [SIZE_W+1:0]   rem_diff;
    logic [PCNT_W-1:0]   new_total;
    logic [PCNT_W-1:0]   pop_j;
    logic [PROD_W-1:0]   prod;

    assign in_cmd    = s_axis_tuser[CMD_W-1:0];
    assign in_size   = s_axis_tdata[15:0];
    assign in_layout = s_axis_tdata[23:16];
    assign in_pnum   = s_axis_tdata[27:24];
    assign in_page   = s_axis_tdata[35:28];

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {4'b0000, m_off_reg, m_page_reg, m_pool_reg};

    // restoring divider step, page count cap, pop index and offset product
    assign rem_sh    = {div_rem_reg[SIZE_W-1:0], div_quo_reg[CAP_W-1]};
    assign rem_diff  = {1'b0, rem_sh} - {2'b00, req_size_reg};
    assign new_total = (div_quo_reg > CAP_W'(MAX_PAGES)) ? PCNT_W'(MAX_PAGES)
                                                         : PCNT_W'(div_quo_reg);
    assign pop_j     = cur_fc_reg - PCNT_W'(1);
    assign prod      = PROD_W'(req_size_reg) * PROD_W'(pg_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        created_next    = created_reg;
        cap_next        = cap_reg;
        req_size_next   = req_size_reg;
        req_layout_next = req_layout_reg;
        req_page_next   = req_page_reg;
        cur_slot_next   = cur_slot_reg;
        cur_total_next  = cur_total_reg;
        cur_fc_next     = cur_fc_reg;
        cur_mark_next   = cur_mark_reg;
        pop_idx_next    = pop_idx_reg;
        pop_fresh_next  = pop_fresh_reg;
        pg_next         = pg_reg;
        div_rem_next    = div_rem_reg;
        div_quo_next    = div_quo_reg;
        div_cnt_next    = div_cnt_reg;
        res_status_next = res_status_reg;
        res_pool_next   = res_pool_reg;
        res_page_next   = res_page_reg;
        res_off_next    = res_off_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_pool_next     = m_pool_reg;
        m_page_next     = m_page_reg;
        m_off_next      = m_off_reg;

        slot_we    = 1'b0;
        slot_waddr = cur_slot_reg;
        slot_wdata = slot_q;
        slot_re    = 1'b0;
        slot_raddr = cur_slot_reg;
        stk_we     = 1'b0;
        stk_waddr  = {cur_slot_reg, PIDX_W'(slot_q.fc)};
        stk_wdata  = PIDX_W'(req_page_reg);
        stk_re     = 1'b0;
        stk_raddr  = {cur_slot_reg, PIDX_W'(pop_j)};

        // register write
        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        // output register drains
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_size_next   = in_size;
                    req_layout_next = in_layout;
                    req_page_next   = in_page;
                    res_pool_next   = '0;
                    res_page_next   = '0;
                    res_off_next    = '0;
                    if (in_cmd == CMD_FREE)
                    begin
                        if (CMP_W'(in_pnum) < CMP_W'(created_reg))
                        begin
                            cur_slot_next = POOL_W'(in_pnum);
                            state_next    = S_FREE_RD;
                        end
                        else
                        begin
                            res_status_next = ST_BAD_FREE;
                            state_next      = S_RESULT;
                        end
                    end
                    else if (in_size == '0)
                    begin
                        res_status_next = ST_ZERO_SIZE;
                        state_next      = S_RESULT;
                    end
                    else if (created_reg == '0)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        cur_slot_next = '0;
                        state_next    = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_SCAN_CMP;
            end

            // key compare on one slot per visit
            S_SCAN_CMP:
            begin
                if (slot_q.size == req_size_reg && slot_q.layout == req_layout_reg &&
                    slot_q.fc != '0)
                begin
                    cur_total_next = slot_q.total;
                    cur_fc_next    = slot_q.fc;
                    cur_mark_next  = slot_q.mark;
                    state_next     = S_POP;
                end
                else if (CNT_W'(cur_slot_reg) + CNT_W'(1) == created_reg)
                begin
                    state_next = S_CREATE;
                end
                else
                begin
                    cur_slot_next = cur_slot_reg + POOL_W'(1);
                    state_next    = S_SCAN_RD;
                end
            end

            S_CREATE:
            begin
                if (created_reg == CNT_W'(MAX_POOLS))
                begin
                    res_status_next = ST_NO_SLOT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    div_rem_next = '0;
                    div_quo_next = cap_reg;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end

            // one quotient bit per cycle
            S_DIV:
            begin
                if (!rem_diff[SIZE_W+1])
                begin
                    div_rem_next = rem_diff[SIZE_W:0];
                    div_quo_next = {div_quo_reg[CAP_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = rem_sh;
                    div_quo_next = {div_quo_reg[CAP_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(CAP_W - 1))
                begin
                    state_next = S_MAKE;
                end
            end

            // new pool record, stack contents implied by the mark
            S_MAKE:
            begin
                slot_we          = 1'b1;
                slot_waddr       = POOL_W'(created_reg);
                slot_wdata.size  = req_size_reg;
                slot_wdata.layout = req_layout_reg;
                slot_wdata.total = new_total;
                slot_wdata.fc    = new_total;
                slot_wdata.mark  = new_total;
                cur_slot_next    = POOL_W'(created_reg);
                cur_total_next   = new_total;
                cur_fc_next      = new_total;
                cur_mark_next    = new_total;
                created_next     = created_reg + CNT_W'(1);
                if (new_total == '0)
                begin
                    res_status_next = ST_NO_PAGE;
                    state_next      = S_RESULT;
                end
                else
                begin
                    state_next = S_POP;
                end
            end

            // pop: entries below the mark were never overwritten and hold their index
            S_POP:
            begin
                stk_re            = 1'b1;
                pop_idx_next      = PIDX_W'(pop_j);
                pop_fresh_next    = (pop_j < cur_mark_reg);
                slot_we           = 1'b1;
                slot_wdata.size   = req_size_reg;
                slot_wdata.layout = req_layout_reg;
                slot_wdata.total  = cur_total_reg;
                slot_wdata.fc     = pop_j;
                slot_wdata.mark   = (pop_j < cur_mark_reg) ? pop_j : cur_mark_reg;
                state_next        = S_POP_RD;
            end

            S_POP_RD:
            begin
                pg_next    = pop_fresh_reg ? pop_idx_reg : stk_q;
                state_next = S_MUL;
            end

            // base offset with saturation
            S_MUL:
            begin
                res_status_next = ST_OK;
                res_pool_next   = POOLNUM_W'(cur_slot_reg);
                res_page_next   = PAGENUM_W'(pg_reg);
                if (SAT_W'(prod) > SAT_W'(OFFSET_MAX))
                begin
                    res_off_next = OFFSET_MAX;
                end
                else
                begin
                    res_off_next = OFFSET_W'(prod);
                end
                state_next = S_RESULT;
            end

            S_FREE_RD:
            begin
                slot_re    = 1'b1;
                state_next = S_FREE_CHK;
            end

            // push back when the page is in range and the stack has room
            S_FREE_CHK:
            begin
                if (PG_CMP_W'(req_page_reg) < PG_CMP_W'(slot_q.total) &&
                    slot_q.fc < slot_q.total)
                begin
                    stk_we          = 1'b1;
                    slot_we         = 1'b1;
                    slot_wdata.fc   = slot_q.fc + PCNT_W'(1);
                    res_status_next = ST_OK;
                end
                else
                begin
                    res_status_next = ST_BAD_FREE;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pool_next   = res_pool_reg;
                    m_page_next   = res_page_reg;
                    m_off_next    = res_off_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            created_reg <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            created_reg <= created_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_size_reg   <= req_size_next;
        req_layout_reg <= req_layout_next;
        req_page_reg   <= req_page_next;
        cur_slot_reg   <= cur_slot_next;
        cur_total_reg  <= cur_total_next;
        cur_fc_reg     <= cur_fc_next;
        cur_mark_reg   <= cur_mark_next;
        pop_idx_reg    <= pop_idx_next;
        pop_fresh_reg  <= pop_fresh_next;
        pg_reg         <= pg_next;
        div_rem_reg    <= div_rem_next;
        div_quo_reg    <= div_quo_next;
        div_cnt_reg    <= div_cnt_next;
        res_status_reg <= res_status_next;
        res_pool_reg   <= res_pool_next;
        res_page_reg   <= res_page_next;
        res_off_reg    <= res_off_next;
        m_status_reg   <= m_status_next;
        m_pool_reg     <= m_pool_next;
        m_page_reg     <= m_page_next;
        m_off_reg      <= m_off_next;
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_q <= slot_mem[slot_raddr];
        end
    end

    // free page stacks
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_q <= stack_mem[stk_raddr];
        end
    end

endmodule

// ----- test/keyed_page_pool_allocator_test.sv -----
module keyed_page_pool_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kppa_pkg::*;

    localparam int MAX_POOLS = 16;
    localparam int MAX_PAGES = 256;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SIZE_W-1:0]    size;
        logic [LAYOUT_W-1:0]  layout;
        logic [POOLNUM_W-1:0] pool;
        logic [PAGENUM_W-1:0] page;
    } pool_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POOLNUM_W-1:0] pool;
        logic [PAGENUM_W-1:0] page;
        logic [OFFSET_W-1:0]  offset;
    } pool_answer_t;

    typedef struct {
        int unsigned pool;
        int unsigned page;
    } loaned_page_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // mirror of the pool table
    logic [CAP_W-1:0]  capacity = CAP_RESET;
    bit                slot_used[MAX_POOLS];
    logic [SIZE_W-1:0] pool_size[MAX_POOLS];
    logic [LAYOUT_W-1:0] pool_layout[MAX_POOLS];
    int unsigned       pool_total[MAX_POOLS];
    int unsigned       pool_free[MAX_POOLS];
    int unsigned       page_stack[MAX_POOLS][MAX_PAGES];
    int unsigned       pools_made = 0;

    pool_answer_t answers_due[$];
    loaned_page_t pages_on_loan[$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    logic [SIZE_W-1:0]   key_sizes[4] = '{16'd4, 16'd12, 16'd100, 16'd1000};
    logic [LAYOUT_W-1:0] key_layouts[2] = '{8'h00, 8'h5A};

    keyed_page_pool_allocator #(
        .MAX_POOLS(MAX_POOLS),
        .MAX_PAGES(MAX_PAGES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // result sink backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // apply one request to the pool table and work out its answer
    task automatic compute_pool_answer(input pool_request_t req, output pool_answer_t ans);
        int slot;
        int unsigned page;
        longint unsigned span;
        ans = '0;
        if (req.cmd == CMD_FREE)
        begin
            slot = int'(req.pool);
            if (!slot_used[slot] || req.page >= pool_total[slot] ||
                pool_free[slot] >= pool_total[slot])
                ans.status = ST_BAD_FREE;
            else
            begin
                page_stack[slot][pool_free[slot]] = 32'(req.page);
                pool_free[slot]++;
                ans.status = ST_OK;
            end
        end
        else if (req.size == 0)
            ans.status = ST_ZERO_SIZE;
        else
        begin
            // lowest matching pool that still has a page
            slot = -1;
            for (int s = 0; s < MAX_POOLS; s++)
                if (slot < 0 && slot_used[s] && pool_size[s] == req.size &&
                    pool_layout[s] == req.layout && pool_free[s] > 0)
                    slot = s;
            // otherwise open a new pool, stack filled in ascending order
            if (slot < 0 && pools_made < MAX_POOLS)
            begin
                slot = pools_made;
                pools_made++;
                slot_used[slot] = 1'b1;
                pool_size[slot] = req.size;
                pool_layout[slot] = req.layout;
                pool_total[slot] = capacity / req.size;
                if (pool_total[slot] > MAX_PAGES)
                    pool_total[slot] = MAX_PAGES;
                pool_free[slot] = pool_total[slot];
                for (int i = 0; i < pool_total[slot]; i++)
                    page_stack[slot][i] = i;
            end
            if (slot < 0)
                ans.status = ST_NO_SLOT;
            else if (pool_free[slot] == 0)
                ans.status = ST_NO_PAGE;
            else
            begin
                pool_free[slot]--;
                page = page_stack[slot][pool_free[slot]];
                span = req.size;
                span = span * page;
                ans.status = ST_OK;
                ans.pool = POOLNUM_W'(slot);
                ans.page = PAGENUM_W'(page);
                ans.offset = (span > OFFSET_MAX) ? OFFSET_MAX : span[OFFSET_W-1:0];
                pages_on_loan.insert(pages_on_loan.size(), '{unsigned'(slot), page});
            end
        end
    endtask

    function automatic pool_request_t alloc_req(logic [SIZE_W-1:0] size,
                                                logic [LAYOUT_W-1:0] layout);
        pool_request_t req;
        req = '0;
        req.cmd = CMD_ALLOC;
        req.size = size;
        req.layout = layout;
        return req;
    endfunction

    function automatic pool_request_t free_req(logic [POOLNUM_W-1:0] pool,
                                               logic [PAGENUM_W-1:0] page);
        pool_request_t req;
        req = '0;
        req.cmd = CMD_FREE;
        req.pool = pool;
        req.page = page;
        return req;
    endfunction

    // send one item, then record its expected answer
    task automatic send_request(input pool_request_t req);
        pool_answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, req.page, req.pool, req.layout, req.size};
        s_axis_tuser <= req.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        compute_pool_answer(req, ans);
        answers_due.insert(answers_due.size(), ans);
    endtask

    // stop sending and wait for every outstanding answer
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (answers_due.size() != 0);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity = value;
    endtask

    // zero page size and free into a pool that does not exist
    task automatic test_request_errors();
        send_request(alloc_req(16'd0, 8'h00));
        send_request(free_req(4'd15, 8'd255));
    endtask

    // pool of 256 unit pages, pop from the top, push back, then overfill
    task automatic test_unit_page_pool();
        send_request(alloc_req(16'd1, 8'h00));
        send_request(alloc_req(16'd1, 8'h00));
        send_request(free_req(4'd0, 8'd255));
        send_request(free_req(4'd0, 8'd254));
        send_request(free_req(4'd0, 8'd0));
    endtask

    // one-page pools: exhaustion opens a second pool, freed page is reused
    task automatic test_single_page_pools();
        send_request(alloc_req(16'hFFFF, 8'hFF));
        send_request(alloc_req(16'hFFFF, 8'hFF));
        send_request(free_req(4'd1, 8'd1));
        send_request(free_req(4'd1, 8'd0));
        send_request(alloc_req(16'hFFFF, 8'hFF));
    endtask

    // smallest capacity: page larger than the pool gives an empty pool
    task automatic test_min_capacity();
        write_capacity(24'd1);
        send_request(alloc_req(16'd2, 8'h81));
        send_request(alloc_req(16'd1, 8'h00));
        send_request(free_req(4'd3, 8'd0));
    endtask

    // largest capacity with the largest page size
    task automatic test_max_capacity();
        write_capacity(24'hFFFFFF);
        send_request(alloc_req(16'hFFFF, 8'h07));
        send_request(free_req(4'd4, 8'd255));
    endtask

    // mostly well-formed alloc/free churn on a few keys, plus noise
    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                       input logic [CAP_W-1:0] cap);
        pool_request_t req;
        loaned_page_t  loan;
        logic [63:0]   noise;
        int            roll;
        int            pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            // sender holds off once until everything has come back
            if (i == count / 2)
                wait_drained();
            noise = {$urandom, $urandom};
            req = noise[$bits(pool_request_t)-1:0];
            roll = $urandom_range(99);
            if (roll < 80 && (roll < 45 || pages_on_loan.size() == 0))
            begin
                req.cmd = CMD_ALLOC;
                req.size = key_sizes[$urandom_range(3)];
                req.layout = key_layouts[$urandom_range(1)];
            end
            else if (roll < 80)
            begin
                pick = $urandom_range(pages_on_loan.size() - 1);
                loan = pages_on_loan[pick];
                pages_on_loan.delete(pick);
                req.cmd = CMD_FREE;
                req.pool = POOLNUM_W'(loan.pool);
                req.page = PAGENUM_W'(loan.page);
            end
            else if (roll < 90)
                req.cmd = CMD_FREE;
            else if (roll < 93)
                req.cmd = CMD_ALLOC;
            else if (roll < 96)
            begin
                req.cmd = CMD_ALLOC;
                req.size = '0;
            end
            else
            begin
                req.cmd = CMD_FREE;
                req.page = 8'd255;
            end
            send_request(req);
        end
    endtask

    // compare each accepted result with the oldest expected answer
    always @(posedge clk)
    begin
        pool_answer_t seen;
        pool_answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.status = m_axis_tuser[2:0];
            seen.pool = m_axis_tdata[3:0];
            seen.page = m_axis_tdata[11:4];
            seen.offset = m_axis_tdata[35:12];
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d pool %0d page %0d offset %0d",
                             seen.status, seen.pool, seen.page, seen.offset);
            end
            else
            begin
                want = answers_due.pop_front();
                if (seen.status !== want.status || seen.pool !== want.pool ||
                    seen.page !== want.page || seen.offset !== want.offset)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d pool %0d page %0d offset %0d,",
                                 want.status, want.pool, want.page, want.offset,
                                 " got status %0d pool %0d page %0d offset %0d",
                                 seen.status, seen.pool, seen.page, seen.offset);
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_request_errors();
        test_unit_page_pool();
        test_single_page_pools();
        test_min_capacity();
        test_max_capacity();
        test_random_traffic(420, 22, 84, 24'd1024);
        test_random_traffic(420, 84, 22, CAP_W'($urandom_range(4000, 1)));
        test_random_traffic(420, 0, 0, 24'd600);

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run time limit
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
